FILE: hdl/mrre_pkg.sv
package mrre_pkg;

    localparam int COORD_W = 13;
    localparam int COUNT_W = 16;
    localparam int PIXEL_W = 8;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    // largest frame; coordinates and sizes are COORD_W bits wide
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // register indexes, byte address is 4 * index
    localparam logic [1:0] REG_TARGET_COLOR = 2'd0;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;
    localparam logic [1:0] REG_RUN_LIMIT    = 2'd3;

    localparam logic [PIXEL_W-1:0] TARGET_COLOR_RST = 8'd0;
    localparam logic [COORD_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [COORD_W-1:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [COUNT_W-1:0] RUN_LIMIT_RST    = 16'd3000;

    localparam logic KIND_RUN     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // one entry of the queue between classifier and result builder
    typedef struct packed {
        logic               has_run;
        logic               frame_end;
        logic [COORD_W-1:0] run_left;
        logic [COORD_W-1:0] run_right;
        logic [COORD_W-1:0] run_row;
        logic [COUNT_W-1:0] count;
        logic               trunc;
    } cmd_t;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] left_col;
        logic [COORD_W-1:0] right_col;
        logic [COORD_W-1:0] top_row;
        logic [COORD_W-1:0] bottom_row;
        logic [COUNT_W-1:0] run_count;
        logic               truncated;
        logic               last;
    } res_t;

    typedef enum logic {
        BK_HEAD,
        BK_SUMMARY
    } back_state_t;

endpackage

FILE: hdl/mrre_pix_if.sv
interface mrre_pix_if;
    import mrre_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

FILE: hdl/mrre_res_if.sv
interface mrre_res_if;
    import mrre_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic [COORD_W-1:0] left_col;
    logic [COORD_W-1:0] right_col;
    logic [COORD_W-1:0] top_row;
    logic [COORD_W-1:0] bottom_row;
    logic [COUNT_W-1:0] run_count;
    logic               truncated;
    logic               last;

    modport source (
        output valid, output kind, output left_col, output right_col,
        output top_row, output bottom_row, output run_count,
        output truncated, output last, input ready
    );
    modport sink (
        input valid, input kind, input left_col, input right_col,
        input top_row, input bottom_row, input run_count,
        input truncated, input last, output ready
    );
endinterface

FILE: hdl/mask_run_rectangle_extractor.sv
// Mask run rectangle extractor.
// pixels: one 8-bit pixel per beat in raster order, valid/ready handshake.
// results: run rectangles (kind 0) and, after the last pixel of a frame, a
// summary beat (kind 1) with the bounding box, run count and truncated flag;
// last marks the final result beat caused by one pixel.
// Configuration through the APB port: target colour, frame width and height
// (used clamped to 1..MAX_WIDTH and 1..MAX_HEIGHT) and run limit; write only
// while no pixel is in flight. pready is always high.
// Throughput: one pixel per cycle while the queue has room. A pixel gives
// zero, one or two result beats; the output register moves one beat per
// cycle while the receiver is ready, and a run closed by the last pixel of
// the frame is followed by its summary beat. A pixel's queue entry is
// written when the pixel is accepted and then moves to the output register.
// A four-entry queue separates the pixel classifier from the result builder;
// when the receiver stalls the queue fills and pixel ready drops.
// Reset clears the position, run state, count, queue and output valid;
// registers return to colour 0, 640 x 480, limit 3000.
module mask_run_rectangle_extractor (
    input  logic                          clk,
    input  logic                          rst_n,
    mrre_pix_if.sink                      pixels,
    mrre_res_if.source                    results,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mrre_pkg::APB_AW-1:0]   paddr,
    input  logic [mrre_pkg::APB_DW-1:0]   pwdata,
    output logic [mrre_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import mrre_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int XW     = CW + 1;
    localparam int YW     = RW + 1;
    localparam int QDEPTH = 4;

    logic [PIXEL_W-1:0] target_color_reg;
    logic [COORD_W-1:0] frame_width_reg;
    logic [COORD_W-1:0] frame_height_reg;
    logic [COUNT_W-1:0] run_limit_reg;

    logic               wr_en;
    logic [1:0]         reg_idx;
    logic [XW-1:0]      width_c;
    logic [YW-1:0]      height_c;
    logic [CW-1:0]      last_col;
    logic [RW-1:0]      last_row;

    logic               cmd_push;
    cmd_t               cmd;
    logic               cmd_full;
    logic               cmd_empty;
    cmd_t               cmd_head;
    logic               cmd_pop;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_color_reg <= TARGET_COLOR_RST;
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            run_limit_reg    <= RUN_LIMIT_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_TARGET_COLOR: target_color_reg <= pwdata[PIXEL_W-1:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[COORD_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[COORD_W-1:0];
                REG_RUN_LIMIT:    run_limit_reg    <= pwdata[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TARGET_COLOR: prdata = APB_DW'(target_color_reg);
            REG_FRAME_WIDTH:  prdata = APB_DW'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height_reg);
            REG_RUN_LIMIT:    prdata = APB_DW'(run_limit_reg);
            default:          prdata = '0;
        endcase
    end

    // frame size as used, clamped to the supported range
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            width_c = XW'(1);
        end
        else if (int'(frame_width_reg) > MAX_WIDTH)
        begin
            width_c = XW'(MAX_WIDTH);
        end
        else
        begin
            width_c = XW'(frame_width_reg);
        end

        if (frame_height_reg == '0)
        begin
            height_c = YW'(1);
        end
        else if (int'(frame_height_reg) > MAX_HEIGHT)
        begin
            height_c = YW'(MAX_HEIGHT);
        end
        else
        begin
            height_c = YW'(frame_height_reg);
        end
    end

    assign last_col = CW'(width_c - XW'(1));
    assign last_row = RW'(height_c - YW'(1));

    mrre_front #(
        .CW (CW),
        .RW (RW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixels       (pixels),
        .target_color (target_color_reg),
        .run_limit    (run_limit_reg),
        .last_col     (last_col),
        .last_row     (last_row),
        .cmd_full     (cmd_full),
        .cmd_push     (cmd_push),
        .cmd          (cmd)
    );

    mrre_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd),
        .pop       (cmd_pop),
        .head      (cmd_head),
        .full      (cmd_full),
        .empty     (cmd_empty)
    );

    mrre_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (cmd_head),
        .head_valid (!cmd_empty),
        .pop        (cmd_pop),
        .frame_w    (COORD_W'(width_c)),
        .frame_h    (COORD_W'(height_c)),
        .results    (results)
    );

endmodule

FILE: hdl/mrre_front.sv
module mrre_front #(
    parameter int CW = 12,
    parameter int RW = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    mrre_pix_if.sink                          pixels,
    input  logic [mrre_pkg::PIXEL_W-1:0]      target_color,
    input  logic [mrre_pkg::COUNT_W-1:0]      run_limit,
    input  logic [CW-1:0]                     last_col,
    input  logic [RW-1:0]                     last_row,
    input  logic                              cmd_full,
    output logic                              cmd_push,
    output mrre_pkg::cmd_t                    cmd
);
    import mrre_pkg::*;

    logic [CW-1:0]      col_reg, col_next;
    logic [RW-1:0]      row_reg, row_next;
    logic               in_run_reg, in_run_next;
    logic [CW-1:0]      run_start_reg, run_start_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               stopped_reg, stopped_next;

    logic               accept;
    logic               match;
    logic               end_row;
    logic               end_frame;
    logic               close_mid;
    logic               close_end;
    logic               has_run;
    logic [CW-1:0]      start_col;
    logic [COUNT_W-1:0] cnt_inc;
    logic               stop_hit;

    assign pixels.ready = !cmd_full;
    assign accept       = pixels.valid && !cmd_full;

    assign match     = (pixels.pixel == target_color) && !stopped_reg;
    assign end_row   = col_reg >= last_col;
    assign end_frame = end_row && (row_reg >= last_row);
    assign start_col = in_run_reg ? run_start_reg : col_reg;
    assign close_mid = in_run_reg && !match;
    assign close_end = match && end_row;
    assign has_run   = close_mid || close_end;
    assign cnt_inc   = cnt_reg + COUNT_W'(1);
    assign stop_hit  = cnt_inc >= run_limit;

    always_comb
    begin
        cmd.has_run   = has_run;
        cmd.frame_end = end_frame;
        cmd.run_left  = COORD_W'(start_col);
        cmd.run_right = close_mid ? COORD_W'(col_reg) : COORD_W'(col_reg) + COORD_W'(1);
        cmd.run_row   = COORD_W'(row_reg);
        cmd.count     = has_run ? cnt_inc : cnt_reg;
        cmd.trunc     = has_run ? stop_hit : stopped_reg;
    end

    assign cmd_push = accept && (has_run || end_frame);

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        in_run_next    = in_run_reg;
        run_start_next = run_start_reg;
        cnt_next       = cnt_reg;
        stopped_next   = stopped_reg;
        if (accept)
        begin
            if (end_frame)
            begin
                col_next       = '0;
                row_next       = '0;
                in_run_next    = 1'b0;
                run_start_next = '0;
                cnt_next       = '0;
                stopped_next   = 1'b0;
            end
            else
            begin
                if (end_row)
                begin
                    col_next = '0;
                    row_next = row_reg + RW'(1);
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
                in_run_next    = match && !end_row;
                run_start_next = start_col;
                if (has_run)
                begin
                    cnt_next     = cnt_inc;
                    stopped_next = stop_hit;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            in_run_reg    <= 1'b0;
            run_start_reg <= '0;
            cnt_reg       <= '0;
            stopped_reg   <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            in_run_reg    <= in_run_next;
            run_start_reg <= run_start_next;
            cnt_reg       <= cnt_next;
            stopped_reg   <= stopped_next;
        end
    end

endmodule

FILE: hdl/mrre_fifo.sv
module mrre_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mrre_pkg::cmd_t push_data,
    input  logic           pop,
    output mrre_pkg::cmd_t head,
    output logic           full,
    output logic           empty
);
    import mrre_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   fill_reg, fill_next;
    logic          do_push;
    logic          do_pop;

    assign full    = fill_reg == (AW+1)'(DEPTH);
    assign empty   = fill_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + (AW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hdl/mrre_back.sv
module mrre_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mrre_pkg::cmd_t                head,
    input  logic                          head_valid,
    output logic                          pop,
    input  logic [mrre_pkg::COORD_W-1:0]  frame_w,
    input  logic [mrre_pkg::COORD_W-1:0]  frame_h,
    mrre_res_if.source                    results
);
    import mrre_pkg::*;

    back_state_t        state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    res_t               res_reg, res_next;
    logic [COORD_W-1:0] box_l_reg, box_l_next;
    logic [COORD_W-1:0] box_r_reg, box_r_next;
    logic [COORD_W-1:0] box_t_reg, box_t_next;
    logic [COORD_W-1:0] box_b_reg, box_b_next;
    logic               load;
    logic               first;
    res_t               run_res;
    res_t               sum_res;

    assign load  = !out_valid_reg || results.ready;
    assign first = head.count == COUNT_W'(1);

    always_comb
    begin
        run_res.kind       = KIND_RUN;
        run_res.left_col   = head.run_left;
        run_res.right_col  = head.run_right;
        run_res.top_row    = head.run_row;
        run_res.bottom_row = head.run_row;
        run_res.run_count  = head.count;
        run_res.truncated  = head.trunc;
        run_res.last       = !head.frame_end;

        // empty frame reports an empty box: left and top at the frame size, right and bottom zero
        sum_res.kind       = KIND_SUMMARY;
        sum_res.run_count  = head.count;
        sum_res.truncated  = head.trunc;
        sum_res.last       = 1'b1;
        if (head.count == '0)
        begin
            sum_res.left_col   = frame_w;
            sum_res.top_row    = frame_h;
            sum_res.right_col  = '0;
            sum_res.bottom_row = '0;
        end
        else
        begin
            sum_res.left_col   = box_l_reg;
            sum_res.top_row    = box_t_reg;
            sum_res.right_col  = box_r_reg;
            sum_res.bottom_row = box_b_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        box_l_next     = box_l_reg;
        box_r_next     = box_r_reg;
        box_t_next     = box_t_reg;
        box_b_next     = box_b_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            BK_HEAD:
            begin
                if (head_valid && load)
                begin
                    out_valid_next = 1'b1;
                    if (head.has_run)
                    begin
                        res_next = run_res;
                        if (first || head.run_left < box_l_reg)
                        begin
                            box_l_next = head.run_left;
                        end
                        if (first || head.run_right > box_r_reg)
                        begin
                            box_r_next = head.run_right;
                        end
                        if (first || head.run_row < box_t_reg)
                        begin
                            box_t_next = head.run_row;
                        end
                        if (first || head.run_row > box_b_reg)
                        begin
                            box_b_next = head.run_row;
                        end
                        if (head.frame_end)
                        begin
                            state_next = BK_SUMMARY;
                        end
                        else
                        begin
                            pop = 1'b1;
                        end
                    end
                    else
                    begin
                        res_next = sum_res;
                        pop      = 1'b1;
                    end
                end
            end
            BK_SUMMARY:
            begin
                // summary after a run closed on the last pixel, box already updated
                if (load)
                begin
                    out_valid_next = 1'b1;
                    res_next       = sum_res;
                    pop            = 1'b1;
                    state_next     = BK_HEAD;
                end
            end
            default:
            begin
                state_next = BK_HEAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_HEAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        box_l_reg <= box_l_next;
        box_r_reg <= box_r_next;
        box_t_reg <= box_t_next;
        box_b_reg <= box_b_next;
    end

    assign results.valid      = out_valid_reg;
    assign results.kind       = res_reg.kind;
    assign results.left_col   = res_reg.left_col;
    assign results.right_col  = res_reg.right_col;
    assign results.top_row    = res_reg.top_row;
    assign results.bottom_row = res_reg.bottom_row;
    assign results.run_count  = res_reg.run_count;
    assign results.truncated  = res_reg.truncated;
    assign results.last       = res_reg.last;

endmodule
